/* hdl/ahlc_pkg.sv */
// Shared types and constants for the axis homing and limit controller.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package ahlc_pkg;

	// Fixed field widths
	localparam int SPEED_W   = 23;
	localparam int METHOD_W  = 2;
	localparam int ARM_VEL_W = 24;
	localparam int ACTION_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SPEED    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_METHOD = 1'b1;

	// Homing method codes as seen on a home rising edge
	localparam logic [METHOD_W-1:0] HM_R_REVERSE = 2'b00; // moving right: reverse and stop
	localparam logic [METHOD_W-1:0] HM_R_HOLD    = 2'b01; // moving right: stop only
	localparam logic [METHOD_W-1:0] HM_L_HOLD    = 2'b10; // moving left: stop only
	localparam logic [METHOD_W-1:0] HM_L_REVERSE = 2'b11; // moving left: reverse and stop

	// Switch events
	typedef enum logic [ACTION_W-1:0] {
		ACT_LEFT_END  = 3'd0,
		ACT_RIGHT_END = 3'd1,
		ACT_HOME_FALL = 3'd2,
		ACT_HOME_RISE = 3'd3,
		ACT_INDEX     = 3'd4,
		ACT_ARM       = 3'd5
	} action_t;

	// Configuration as seen by the event logic
	typedef struct packed {
		logic [SPEED_W-1:0]  sync_speed;
		logic [METHOD_W-1:0] homing_method;
	} cfg_t;

	// Single-bit axis status reported with each result
	typedef struct packed {
		logic moving_right;
		logic sync_on;
		logic stop_pending;
		logic index_stop;
	} flags_t;

endpackage

`default_nettype wire

/* hdl/ahlc_cfg.sv */
// Configuration registers of the axis homing and limit controller.
// Depends on ahlc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ahlc_cfg import ahlc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_DAT_W-1:0] wr_data,
	output      cfg_t                 cfg
);

	logic [SPEED_W-1:0]  sync_speed_q;
	logic [METHOD_W-1:0] homing_method_q;

	// Take a register write, keeping only the register's own bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_speed_q    <= '0;
			homing_method_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SYNC_SPEED:    sync_speed_q    <= wr_data[SPEED_W-1:0];
				CFG_HOMING_METHOD: homing_method_q <= wr_data[METHOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sync_speed    = sync_speed_q;
	assign cfg.homing_method = homing_method_q;

endmodule

`default_nettype wire

/* hdl/ahlc_core.sv */
// Axis state registers and the per-event update rule.
// Depends on ahlc_pkg for action codes, homing method codes and bundles.
`default_nettype none

module ahlc_core import ahlc_pkg::*; #(
	parameter int VELOCITY_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input       action_t                         action,
	input  wire logic                            arm_direction,
	input  wire logic signed [ARM_VEL_W-1:0]     arm_velocity,
	input  wire logic                            arm_enable,
	input       cfg_t                            cfg,
	output      logic signed [VELOCITY_BITS-1:0] vel_nxt,
	output      flags_t                          flags_nxt
);

	// Compare width wide enough for both the arm field and the velocity limit
	localparam int CW = (VELOCITY_BITS > ARM_VEL_W) ? VELOCITY_BITS : ARM_VEL_W;
	localparam logic signed [CW-1:0] LIM_POS = CW'({1'b0, {(VELOCITY_BITS-1){1'b1}}});
	localparam logic signed [CW-1:0] LIM_NEG = -LIM_POS;

	logic signed [VELOCITY_BITS-1:0] vel_q;
	logic                            dir_q;
	logic                            en_q;
	logic                            stop_q;

	logic signed [CW-1:0]            speed_ext;
	logic signed [CW-1:0]            speed_sat;
	logic signed [CW-1:0]            arm_ext;
	logic signed [CW-1:0]            arm_sat;
	logic signed [VELOCITY_BITS-1:0] vel_right;
	logic signed [VELOCITY_BITS-1:0] vel_left;
	logic signed [VELOCITY_BITS-1:0] vel_arm;
	logic                            dir_nxt;
	logic                            en_nxt;
	logic                            stop_nxt;
	logic                            idx_nxt;

	// Clamp the homing speed and the armed velocity to the symmetric range
	always_comb begin
		speed_ext = CW'(cfg.sync_speed);
		speed_sat = (speed_ext > LIM_POS) ? LIM_POS : speed_ext;
		arm_ext   = CW'(arm_velocity);
		if (arm_ext > LIM_POS)
			arm_sat = LIM_POS;
		else if (arm_ext < LIM_NEG)
			arm_sat = LIM_NEG;
		else
			arm_sat = arm_ext;
		vel_right = speed_sat[VELOCITY_BITS-1:0];
		vel_left  = -vel_right;
		vel_arm   = arm_sat[VELOCITY_BITS-1:0];
	end

	// Work out the state after this event
	always_comb begin
		vel_nxt  = vel_q;
		dir_nxt  = dir_q;
		en_nxt   = en_q;
		stop_nxt = stop_q;
		idx_nxt  = 1'b0;
		case (action)
			ACT_LEFT_END: begin
				if (!en_q) begin
					vel_nxt = '0;
				end else if (!dir_q) begin
					vel_nxt = vel_right;
					dir_nxt = 1'b1;
				end
			end
			ACT_RIGHT_END: begin
				if (!en_q) begin
					vel_nxt = '0;
				end else if (dir_q) begin
					vel_nxt = vel_left;
					dir_nxt = 1'b0;
				end
			end
			ACT_HOME_FALL: begin
				// reverse when method bit 0 disagrees with the direction
				stop_nxt = 1'b1;
				if (cfg.homing_method[0] != dir_q) begin
					vel_nxt = dir_q ? vel_left : vel_right;
					dir_nxt = !dir_q;
				end
			end
			ACT_HOME_RISE: begin
				if (!dir_q) begin
					if (cfg.homing_method == HM_L_HOLD) begin
						stop_nxt = 1'b1;
					end else if (cfg.homing_method == HM_L_REVERSE) begin
						stop_nxt = 1'b1;
						vel_nxt  = vel_right;
						dir_nxt  = 1'b1;
					end
				end else begin
					if (cfg.homing_method == HM_R_REVERSE) begin
						stop_nxt = 1'b1;
						vel_nxt  = vel_left;
						dir_nxt  = 1'b0;
					end else if (cfg.homing_method == HM_R_HOLD) begin
						stop_nxt = 1'b1;
					end
				end
			end
			ACT_INDEX: begin
				if (stop_q) begin
					idx_nxt = en_q;
					en_nxt  = 1'b0;
				end
			end
			ACT_ARM: begin
				vel_nxt = vel_arm;
				dir_nxt = arm_direction;
				en_nxt  = arm_enable;
			end
			default: ;
		endcase
	end

	assign flags_nxt.moving_right = dir_nxt;
	assign flags_nxt.sync_on      = en_nxt;
	assign flags_nxt.stop_pending = stop_nxt;
	assign flags_nxt.index_stop   = idx_nxt;

	// Commit the new state when the event moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q  <= '0;
			dir_q  <= 1'b0;
			en_q   <= 1'b0;
			stop_q <= 1'b0;
		end else if (step) begin
			vel_q  <= vel_nxt;
			dir_q  <= dir_nxt;
			en_q   <= en_nxt;
			stop_q <= stop_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/axis_homing_limit_controller.sv */
// Axis homing and limit-switch controller: one switch event in, one status result out.
// Each event is registered on transfer, applied to the axis state when it moves on, and
// the new state lands in an output register; a new event can be taken every cycle while
// the result channel is not stalled, so throughput is one event per clock. The update path
// through ahlc_core is combinational between the input and output registers.
// Configuration is written over the cfg port (index 0 sync_speed, 1 homing_method),
// which is always ready; write it only while no event is in flight.
// Uses ahlc_pkg, ahlc_cfg and ahlc_core.
`default_nettype none

module axis_homing_limit_controller import ahlc_pkg::*; #(
	parameter int VELOCITY_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [CFG_DAT_W-1:0]            cfg_data,
	// event channel
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [ACTION_W-1:0]             action,
	input  wire logic                            arm_direction,
	input  wire logic signed [ARM_VEL_W-1:0]     arm_velocity,
	input  wire logic                            arm_enable,
	// result channel
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic signed [VELOCITY_BITS-1:0] target_velocity,
	output      logic                            moving_right,
	output      logic                            sync_on,
	output      logic                            stop_pending,
	output      logic                            index_stop
);

	cfg_t                            cfg;
	logic                            valid_s1;
	action_t                         action_s1;
	logic                            arm_direction_s1;
	logic signed [ARM_VEL_W-1:0]     arm_velocity_s1;
	logic                            arm_enable_s1;
	logic                            advance;
	logic                            in_xfer;
	logic signed [VELOCITY_BITS-1:0] vel_nxt;
	flags_t                          flags_nxt;
	logic                            out_valid_q;
	logic signed [VELOCITY_BITS-1:0] vel_q;
	flags_t                          flags_q;

	assign cfg_ready = 1'b1;

	ahlc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the held event on whenever the result register is free or draining
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_xfer  = in_valid & ~in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_xfer | advance)
			valid_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1        <= action_t'(action);
			arm_direction_s1 <= arm_direction;
			arm_velocity_s1  <= arm_velocity;
			arm_enable_s1    <= arm_enable;
		end
	end

	ahlc_core #(
		.VELOCITY_BITS (VELOCITY_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.action        (action_s1),
		.arm_direction (arm_direction_s1),
		.arm_velocity  (arm_velocity_s1),
		.arm_enable    (arm_enable_s1),
		.cfg           (cfg),
		.vel_nxt       (vel_nxt),
		.flags_nxt     (flags_nxt)
	);

	// Result register: hold while stalled, drop valid after a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (~out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vel_q   <= vel_nxt;
			flags_q <= flags_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign target_velocity = vel_q;
	assign moving_right    = flags_q.moving_right;
	assign sync_on         = flags_q.sync_on;
	assign stop_pending    = flags_q.stop_pending;
	assign index_stop      = flags_q.index_stop;

endmodule

`default_nettype wire

/* hdl/ahlc_checker.sv */
// Port-level checks for the axis homing and limit controller, bound to the top level.
// Depends on ahlc_pkg for field widths.
`default_nettype none

module ahlc_checker import ahlc_pkg::*; #(
	parameter int VELOCITY_BITS = 24
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            cfg_ready,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic signed [VELOCITY_BITS-1:0] target_velocity,
	input wire logic                            sync_on,
	input wire logic                            stop_pending,
	input wire logic                            index_stop
);

	localparam logic [VELOCITY_BITS-1:0] VEL_MOST_NEG = {1'b1, {(VELOCITY_BITS-1){1'b0}}};

	// A stalled result keeps its velocity
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_velocity))
		else $error("stalled result changed");

	// An index stop ends sync and only happens with a stop pending
	a_index_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_stop |-> !sync_on && stop_pending)
		else $error("index stop with sync still on or no stop pending");

	// Velocity stays inside the symmetric range
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> target_velocity != VEL_MOST_NEG)
		else $error("target velocity outside symmetric range");

	// The configuration port never refuses a write
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind axis_homing_limit_controller ahlc_checker #(
	.VELOCITY_BITS (VELOCITY_BITS)
) u_ahlc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cfg_ready       (cfg_ready),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.target_velocity (target_velocity),
	.sync_on         (sync_on),
	.stop_pending    (stop_pending),
	.index_stop      (index_stop)
);

`default_nettype wire

/* sim/axis_homing_limit_controller_tb.sv */
// Self-checking testbench for axis_homing_limit_controller: directed switch events, then
// random event streams over several register settings and idling phases.
// Depends on ahlc_pkg and the RTL in hdl; carries its own model of the axis state.
`default_nettype none

module axis_homing_limit_controller_tb;
	import ahlc_pkg::*;

	localparam int VEL_W          = 24;
	localparam int IDLE_LIMIT     = 2000;
	localparam int CHUNKS         = 5;
	localparam int CHUNK_EVENTS   = 25;
	localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
	localparam logic signed [VEL_W-1:0] VEL_MAX      = 24'sh7FFFFF;
	localparam logic [VEL_W-1:0]        VEL_MOST_NEG = 24'h800000;

	typedef struct packed {
		logic [VEL_W-1:0] velocity;
		logic             right;
		logic             sync;
		logic             stop;
		logic             idx_stop;
	} axis_status_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_SYNC_SPEED;
	logic [CFG_DAT_W-1:0]        cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [ACTION_W-1:0]         action = ACT_LEFT_END;
	logic                        arm_direction = 1'b0;
	logic signed [ARM_VEL_W-1:0] arm_velocity = '0;
	logic                        arm_enable = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [VEL_W-1:0]     target_velocity;
	logic                        moving_right;
	logic                        sync_on;
	logic                        stop_pending;
	logic                        index_stop;

	// axis model state and its copy of the registers
	logic                    axis_right = 1'b0;
	logic signed [VEL_W-1:0] axis_vel = '0;
	logic                    axis_sync = 1'b0;
	logic                    axis_stop = 1'b0;
	logic [SPEED_W-1:0]      set_speed = '0;
	logic [METHOD_W-1:0]     set_method = '0;

	axis_status_t expected_status[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	axis_homing_limit_controller #(.VELOCITY_BITS(VEL_W)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.arm_direction(arm_direction), .arm_velocity(arm_velocity),
		.arm_enable(arm_enable),
		.out_valid(out_valid), .out_stall(out_stall), .target_velocity(target_velocity),
		.moving_right(moving_right), .sync_on(sync_on), .stop_pending(stop_pending),
		.index_stop(index_stop)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// reverse toward the right or left at the configured speed
	function automatic void turn_right();
		axis_vel   = {1'b0, set_speed};
		axis_right = 1'b1;
	endfunction

	function automatic void turn_left();
		axis_vel   = -{1'b0, set_speed};
		axis_right = 1'b0;
	endfunction

	// apply one switch event to the axis model and return the status it reports
	function automatic axis_status_t step_axis(logic [ACTION_W-1:0] act, logic a_dir,
			logic [VEL_W-1:0] a_vel, logic a_en);
		axis_status_t r;
		logic ended;
		ended = 1'b0;
		case (act)
			ACT_LEFT_END: begin
				if (axis_sync) begin
					if (!axis_right) turn_right();
				end else begin
					axis_vel = '0;
				end
			end
			ACT_RIGHT_END: begin
				if (axis_sync) begin
					if (axis_right) turn_left();
				end else begin
					axis_vel = '0;
				end
			end
			ACT_HOME_FALL: begin
				if (!axis_right && set_method[0]) turn_right();
				else if (axis_right && !set_method[0]) turn_left();
				axis_stop = 1'b1;
			end
			ACT_HOME_RISE: begin
				if (!axis_right) begin
					if (set_method == HM_L_HOLD) begin
						axis_stop = 1'b1;
					end else if (set_method == HM_L_REVERSE) begin
						turn_right();
						axis_stop = 1'b1;
					end
				end else begin
					if (set_method == HM_R_REVERSE) begin
						turn_left();
						axis_stop = 1'b1;
					end else if (set_method == HM_R_HOLD) begin
						axis_stop = 1'b1;
					end
				end
			end
			ACT_INDEX: begin
				if (axis_stop) begin
					ended     = axis_sync;
					axis_sync = 1'b0;
				end
			end
			ACT_ARM: begin
				// the most negative code saturates to the symmetric limit
				axis_vel   = (a_vel == VEL_MOST_NEG) ? -VEL_MAX : a_vel;
				axis_right = a_dir;
				axis_sync  = a_en;
			end
			default: ;
		endcase
		r.velocity = axis_vel;
		r.right    = axis_right;
		r.sync     = axis_sync;
		r.stop     = axis_stop;
		r.idx_stop = ended;
		return r;
	endfunction

	// predict on each event transfer, check each result transfer
	always @(posedge clk) begin
		axis_status_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_status.size() == 0) begin
				$error("result transfer with no status expected");
				mismatch_count++;
			end else begin
				want = expected_status.pop_front();
				if (target_velocity !== want.velocity) begin
					$error("target_velocity: expected %0d, got %0d",
						$signed(want.velocity), target_velocity);
					mismatch_count++;
				end
				if (moving_right !== want.right) begin
					$error("moving_right: expected %0b, got %0b", want.right, moving_right);
					mismatch_count++;
				end
				if (sync_on !== want.sync) begin
					$error("sync_on: expected %0b, got %0b", want.sync, sync_on);
					mismatch_count++;
				end
				if (stop_pending !== want.stop) begin
					$error("stop_pending: expected %0b, got %0b", want.stop, stop_pending);
					mismatch_count++;
				end
				if (index_stop !== want.idx_stop) begin
					$error("index_stop: expected %0b, got %0b", want.idx_stop, index_stop);
					mismatch_count++;
				end
			end
		end
		if (in_valid === 1'b1 && in_stall === 1'b0)
			expected_status.push_back(step_axis(action, arm_direction, arm_velocity, arm_enable));
	end

	// stall the result channel at the phase's rate
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// send one event, with a random idle gap first; valid stays high afterwards
	task automatic send_event(logic [ACTION_W-1:0] act, logic a_dir = 1'b0,
			logic [ARM_VEL_W-1:0] a_vel = '0, logic a_en = 1'b0);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid      <= 1'b1;
		action        <= act;
		arm_direction <= a_dir;
		arm_velocity  <= a_vel;
		arm_enable    <= a_en;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold off the sender until every expected status has arrived
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers back to back; call only while idle
	task automatic write_config(logic [CFG_DAT_W-1:0] speed_word,
			logic [CFG_DAT_W-1:0] method_word);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SYNC_SPEED;
		cfg_data  <= speed_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		set_speed = speed_word[SPEED_W-1:0];
		cfg_index <= CFG_HOMING_METHOD;
		cfg_data  <= method_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		set_method = method_word[METHOD_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic test_endstops_and_arm();
		write_config(32'hFFFF_FFFF, 32'h0000_0003);
		send_event(ACT_LEFT_END);
		send_event(ACT_ARM, 1'b0, VEL_MAX, 1'b1);
		send_event(ACT_INDEX);
		send_event(ACT_LEFT_END);
		send_event(ACT_LEFT_END);
		send_event(ACT_RIGHT_END);
		send_event(ACT_RIGHT_END);
		send_event(ACT_ARM, 1'b1, VEL_MOST_NEG, 1'b0);
		send_event(ACT_RIGHT_END);
		send_event(ACT_ARM, 1'b1, '0, 1'b1);
		wait_idle();
	endtask

	task automatic test_home_edges();
		write_config(32'h0000_0001, 32'h0000_0001);
		send_event(ACT_ARM, 1'b0, 24'hFFFFFF, 1'b1);
		send_event(ACT_HOME_FALL);
		send_event(ACT_HOME_FALL);
		send_event(ACT_HOME_RISE);
		wait_idle();
		write_config(32'h0055_5555, 32'hFFFF_FFFC);
		send_event(ACT_HOME_FALL);
		send_event(ACT_HOME_RISE);
		send_event(ACT_ARM, 1'b1, 24'h000001, 1'b1);
		send_event(ACT_HOME_RISE);
	endtask

	task automatic test_index_stop();
		send_event(ACT_INDEX);
		send_event(ACT_INDEX);
		send_event(ACT_ARM, 1'b0, 24'h2AAAAA, 1'b1);
		send_event(ACT_INDEX);
	endtask

	task automatic test_unused_actions();
		send_event(ACT_SPARE_6);
		send_event(ACT_SPARE_7);
		wait_idle();
	endtask

	// random mixes of arm events, edges, endstops and index pulses, a few spare codes
	task automatic test_random(int sender_idle, int receiver_stall, int phase);
		int pick;
		logic [CFG_DAT_W-1:0] speed_word;
		logic [ACTION_W-1:0] act;
		logic [ARM_VEL_W-1:0] vel;
		gap_pct   = sender_idle;
		stall_pct = receiver_stall;
		for (int c = 0; c < CHUNKS; c++) begin
			speed_word = $urandom();
			if (c == 0) speed_word[SPEED_W-1:0] = '0;
			else if (c == 1) speed_word[SPEED_W-1:0] = '1;
			write_config(speed_word, {$urandom() & 32'hFFFF_FFFC} | ((c + phase) % 4));
			for (int n = 0; n < CHUNK_EVENTS; n++) begin
				pick = $urandom_range(99);
				if (pick < 20) act = ACT_ARM;
				else if (pick < 35) act = ACT_LEFT_END;
				else if (pick < 50) act = ACT_RIGHT_END;
				else if (pick < 65) act = ACT_HOME_FALL;
				else if (pick < 80) act = ACT_HOME_RISE;
				else if (pick < 95) act = ACT_INDEX;
				else act = pick[0] ? ACT_SPARE_6 : ACT_SPARE_7;
				vel = ARM_VEL_W'($urandom());
				if ($urandom_range(19) == 0) vel = VEL_MOST_NEG;
				else if ($urandom_range(19) == 0) vel = VEL_MAX;
				send_event(act, 1'($urandom_range(1)), vel, $urandom_range(3) != 0);
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_endstops_and_arm();
		test_home_edges();
		test_index_stop();
		test_unused_actions();
		test_random(0, 0, 0);
		test_random(76, 0, 1);
		test_random(0, 76, 2);
		test_random(30, 30, 3);
		stall_pct = 0;
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
